### hw/rtl/first_fit_coalescing_allocator_core_macros.svh
// assertion macros used by the allocator core rtl
`ifndef FIRST_FIT_COALESCING_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_COALESCING_ALLOCATOR_CORE_MACROS_SVH

// assert that a property holds on every edge out of reset
`define FFCA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// assert that a condition is never seen on an edge out of reset
`define FFCA_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### hw/rtl/ffca_pkg.sv
// shared types, constants and status codes of the first-fit allocator
package ffca_pkg;

  localparam int unsigned FreeEntries  = 16;
  localparam int unsigned AllocEntries = 16;
  localparam int unsigned AddrBits     = 16;
  localparam logic [15:0] DefaultMemorySize = 16'd4000;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StNoSpace  = 3'd1;
  localparam logic [2:0] StNotFound = 3'd2;
  localparam logic [2:0] StFull     = 3'd3;
  localparam logic [2:0] StZero     = 3'd4;

  // commands broadcast from the sequencer to the free cell chain
  typedef enum logic [2:0] {
    FcNone,
    FcInit,
    FcShrink,
    FcRemove,
    FcGrowPrev,
    FcMerge,
    FcGrowNext,
    FcInsert
  } free_cmd_e;

  typedef struct packed {
    free_cmd_e   cmd;
    logic [31:0] start;
    logic [31:0] len;
    logic [8:0]  pos;
  } free_ctl_t;

endpackage

### hw/rtl/ffca_free_cell.sv
// one free table entry: a cell that shifts with its neighbours on insert, remove and merge
module ffca_free_cell #(
  parameter int unsigned AddrBits = ffca_pkg::AddrBits,
  parameter int unsigned IdxBits  = 5,
  parameter int unsigned Index    = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ffca_pkg::free_ctl_t ctl_i,
  input  logic                prev_valid_i,
  input  logic [AddrBits-1:0] prev_start_i,
  input  logic [AddrBits-1:0] prev_len_i,
  input  logic                next_valid_i,
  input  logic [AddrBits-1:0] next_start_i,
  input  logic [AddrBits-1:0] next_len_i,
  output logic                valid_o,
  output logic [AddrBits-1:0] start_o,
  output logic [AddrBits-1:0] len_o
);

  localparam logic [IdxBits-1:0] MyIdx = IdxBits'(Index);

  logic                valid_q, valid_d;
  logic [AddrBits-1:0] start_q, start_d, len_q, len_d;
  logic [IdxBits-1:0]  pos;
  logic [AddrBits-1:0] cstart, clen;

  assign pos    = ctl_i.pos[IdxBits-1:0];
  assign cstart = ctl_i.start[AddrBits-1:0];
  assign clen   = ctl_i.len[AddrBits-1:0];

  // next entry contents for each command
  always_comb begin
    valid_d = valid_q;
    start_d = start_q;
    len_d   = len_q;
    unique case (ctl_i.cmd)
      ffca_pkg::FcInit: begin
        valid_d = (Index == 0) && (clen != '0);
        start_d = '0;
        len_d   = clen;
      end
      ffca_pkg::FcShrink: begin
        if (MyIdx == pos) begin
          start_d = start_q + clen;
          len_d   = len_q - clen;
        end
      end
      ffca_pkg::FcRemove: begin
        if (MyIdx >= pos) begin
          valid_d = next_valid_i;
          start_d = next_start_i;
          len_d   = next_len_i;
        end
      end
      ffca_pkg::FcGrowPrev: begin
        if (MyIdx == pos) len_d = len_q + clen;
      end
      ffca_pkg::FcMerge: begin
        if (MyIdx == pos) begin
          len_d = len_q + clen + next_len_i;
        end else if (MyIdx > pos) begin
          valid_d = next_valid_i;
          start_d = next_start_i;
          len_d   = next_len_i;
        end
      end
      ffca_pkg::FcGrowNext: begin
        if (MyIdx == pos) begin
          start_d = cstart;
          len_d   = len_q + clen;
        end
      end
      ffca_pkg::FcInsert: begin
        if (MyIdx == pos) begin
          valid_d = 1'b1;
          start_d = cstart;
          len_d   = clen;
        end else if (MyIdx > pos) begin
          valid_d = prev_valid_i;
          start_d = prev_start_i;
          len_d   = prev_len_i;
        end
      end
      default: ;
    endcase
  end

  // entry registers; reset leaves the default single block in entry 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= (Index == 0);
      start_q <= '0;
      len_q   <= (Index == 0) ? AddrBits'(ffca_pkg::DefaultMemorySize) : '0;
    end else begin
      valid_q <= valid_d;
      start_q <= start_d;
      len_q   <= len_d;
    end
  end

  assign valid_o = valid_q;
  assign start_o = start_q;
  assign len_o   = len_q;

endmodule

### hw/rtl/ffca_free_chain.sv
// row of free table cells kept sorted by address, with a scan tap at a chosen entry
module ffca_free_chain #(
  parameter int unsigned FreeEntries = ffca_pkg::FreeEntries,
  parameter int unsigned AddrBits    = ffca_pkg::AddrBits,
  parameter int unsigned IdxBits     = $clog2(FreeEntries)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ffca_pkg::free_ctl_t ctl_i,
  input  logic [IdxBits-1:0]  rd_idx_i,
  output logic                rd_valid_o,
  output logic [AddrBits-1:0] rd_start_o,
  output logic [AddrBits-1:0] rd_len_o,
  output logic                full_o
);

  logic [FreeEntries-1:0]               valid;
  logic [FreeEntries-1:0][AddrBits-1:0] start, len;

  for (genvar g = 0; g < FreeEntries; g++) begin : g_cell
    logic                pv, nv;
    logic [AddrBits-1:0] ps, pl, ns, nl;
    if (g == 0) begin : g_first
      assign pv = 1'b0;
      assign ps = '0;
      assign pl = '0;
    end else begin : g_mid
      assign pv = valid[g-1];
      assign ps = start[g-1];
      assign pl = len[g-1];
    end
    if (g == FreeEntries - 1) begin : g_last
      assign nv = 1'b0;
      assign ns = '0;
      assign nl = '0;
    end else begin : g_inner
      assign nv = valid[g+1];
      assign ns = start[g+1];
      assign nl = len[g+1];
    end
    ffca_free_cell #(
      .AddrBits(AddrBits),
      .IdxBits (IdxBits),
      .Index   (g)
    ) u_cell (
      .clk_i,
      .rst_ni,
      .ctl_i,
      .prev_valid_i(pv),
      .prev_start_i(ps),
      .prev_len_i  (pl),
      .next_valid_i(nv),
      .next_start_i(ns),
      .next_len_i  (nl),
      .valid_o     (valid[g]),
      .start_o     (start[g]),
      .len_o       (len[g])
    );
  end

  // scan tap read by the sequencer one entry per cycle
  assign rd_valid_o = valid[rd_idx_i];
  assign rd_start_o = start[rd_idx_i];
  assign rd_len_o   = len[rd_idx_i];
  assign full_o     = valid[FreeEntries-1];

endmodule

### hw/rtl/first_fit_coalescing_allocator_core.sv
// first-fit allocator: a request is taken only while idle; its response follows the scans
// of the allocation table and then the free table, one entry per cycle (a zero-size alloc
// skips them), and the next request is taken only once the response is registered;
// a response still waiting in the output register stalls the next request at its output step;
// reset (or a memory_size write) leaves one free block [0, memory_size) if nonzero, and no allocations;
// the allocation table needs no clearing pass, its valid bits clear at once
module first_fit_coalescing_allocator_core #(
  parameter int unsigned FREE_ENTRIES  = ffca_pkg::FreeEntries,
  parameter int unsigned ALLOC_ENTRIES = ffca_pkg::AllocEntries,
  parameter int unsigned ADDR_BITS     = ffca_pkg::AddrBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,       // memory_size
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,      // process_id [15:0], request_size [31:16]
  input  logic        s_axis_tuser,      // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata       // status [2:0], region_start [18:3], region_size [34:19]
);

  localparam int unsigned FIdx = $clog2(FREE_ENTRIES);
  localparam int unsigned AIdx = (ALLOC_ENTRIES > 1) ? $clog2(ALLOC_ENTRIES) : 1;
  localparam int unsigned AgeBits = AIdx + 1;
  localparam logic [FIdx:0] FLast = (FIdx+1)'(FREE_ENTRIES - 1);
  localparam logic [AIdx:0] ALast = (AIdx+1)'(ALLOC_ENTRIES - 1);

  localparam logic [3:0] SIdle    = 4'd0;
  localparam logic [3:0] SAScan   = 4'd1;
  localparam logic [3:0] SFScan   = 4'd2;
  localparam logic [3:0] SAUpd    = 4'd3;
  localparam logic [3:0] SFind    = 4'd4;
  localparam logic [3:0] SPosScan = 4'd5;
  localparam logic [3:0] SPrev    = 4'd6;
  localparam logic [3:0] SDecide  = 4'd7;
  localparam logic [3:0] SRelease = 4'd8;
  localparam logic [3:0] SOut     = 4'd9;

  logic [3:0] state_q, state_d;
  logic       mode_q;
  logic [15:0] pid_q, size_q;
  logic [FIdx:0] fidx_q, fidx_d;
  logic [AIdx:0] aidx_q, aidx_d;
  logic          slot_ok_q, slot_ok_d;
  logic [AIdx-1:0] slot_q, slot_d;
  logic          best_ok_q, best_ok_d;
  logic [AIdx-1:0] best_q, best_d;
  logic [AgeBits-1:0] best_age_q, best_age_d;
  logic [ADDR_BITS-1:0] rs_q, rs_d, rl_q, rl_d;
  logic                 pend_ok_q, pend_ok_d;
  logic                 rd_prev_ok_q;
  logic [2:0]  st_q, st_d;
  logic        out_v_q, out_v_d;
  logic [39:0] out_q, out_d;

  // allocation table: valid and age in flops, payload fields in registers
  logic [ALLOC_ENTRIES-1:0]              av_q;
  logic [ALLOC_ENTRIES-1:0][AgeBits-1:0] age_q;
  logic [ALLOC_ENTRIES-1:0][15:0]        owner_q;
  logic [ALLOC_ENTRIES-1:0][ADDR_BITS-1:0] astart_q, alen_q;
  logic do_alloc, do_release;

  ffca_pkg::free_ctl_t ctl;
  logic [FIdx-1:0]      rd_idx;
  logic                 rd_valid, f_full;
  logic [ADDR_BITS-1:0] rd_start, rd_len;
  logic [AIdx-1:0]      aidx;
  logic [ADDR_BITS-1:0] req_size;

  assign rd_idx   = fidx_q[FIdx-1:0];
  assign aidx     = aidx_q[AIdx-1:0];
  assign req_size = ADDR_BITS'(size_q);

  ffca_free_chain #(
    .FreeEntries(FREE_ENTRIES),
    .AddrBits   (ADDR_BITS),
    .IdxBits    (FIdx)
  ) u_chain (
    .clk_i,
    .rst_ni,
    .ctl_i     (ctl),
    .rd_idx_i  (rd_idx),
    .rd_valid_o(rd_valid),
    .rd_start_o(rd_start),
    .rd_len_o  (rd_len),
    .full_o    (f_full)
  );

  assign s_axis_tready = (state_q == SIdle);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  // request sequencer
  always_comb begin
    state_d    = state_q;
    fidx_d     = fidx_q;
    aidx_d     = aidx_q;
    slot_ok_d  = slot_ok_q;
    slot_d     = slot_q;
    best_ok_d  = best_ok_q;
    best_d     = best_q;
    best_age_d = best_age_q;
    rs_d       = rs_q;
    rl_d       = rl_q;
    pend_ok_d  = pend_ok_q;
    st_d       = st_q;
    out_v_d    = out_v_q;
    out_d      = out_q;
    do_alloc   = 1'b0;
    do_release = 1'b0;
    ctl        = '{cmd: ffca_pkg::FcNone, start: '0, len: '0, pos: '0};
    if (m_axis_tvalid && m_axis_tready) out_v_d = 1'b0;
    if (cfg_we_i) begin
      ctl.cmd = ffca_pkg::FcInit;
      ctl.len = 32'(cfg_wdata_i);
    end
    unique case (state_q)
      SIdle: begin
        if (s_axis_tvalid && s_axis_tready) begin
          aidx_d    = '0;
          fidx_d    = '0;
          slot_ok_d = 1'b0;
          best_ok_d = 1'b0;
          rs_d      = '0;
          rl_d      = '0;
          if (!s_axis_tuser && s_axis_tdata[31:16] == '0) begin
            st_d    = ffca_pkg::StZero;
            state_d = SOut;
          end else begin
            state_d = SAScan;
          end
        end
      end
      SAScan: begin
        // one allocation slot per cycle: free slot or newest owner match
        if (!mode_q) begin
          if (!av_q[aidx] && !slot_ok_q) begin
            slot_ok_d = 1'b1;
            slot_d    = aidx;
          end
        end else if (av_q[aidx] && owner_q[aidx] == pid_q &&
                     (!best_ok_q || age_q[aidx] < best_age_q)) begin
          best_ok_d  = 1'b1;
          best_d     = aidx;
          best_age_d = age_q[aidx];
        end
        aidx_d = aidx_q + 1'b1;
        if (aidx_q == ALast) begin
          if (!mode_q) begin
            if (slot_ok_d) state_d = SFScan;
            else begin
              st_d    = ffca_pkg::StFull;
              state_d = SOut;
            end
          end else if (best_ok_d) begin
            state_d = SPosScan;
          end else begin
            st_d    = ffca_pkg::StNotFound;
            state_d = SOut;
          end
        end
      end
      SFScan: begin
        // first fit over the sorted free table
        if (!rd_valid) begin
          st_d    = ffca_pkg::StNoSpace;
          state_d = SOut;
        end else if (rd_len >= req_size) begin
          rs_d    = rd_start;
          rl_d    = req_size;
          ctl.cmd = (rd_len == req_size) ? ffca_pkg::FcRemove : ffca_pkg::FcShrink;
          ctl.len = 32'(req_size);
          ctl.pos = 9'(fidx_q);
          state_d = SAUpd;
        end else if (fidx_q == FLast) begin
          st_d    = ffca_pkg::StNoSpace;
          state_d = SOut;
        end else begin
          fidx_d = fidx_q + 1'b1;
        end
      end
      SAUpd: begin
        do_alloc = 1'b1;
        st_d     = ffca_pkg::StOk;
        state_d  = SOut;
      end
      SPosScan: begin
        // find the first free entry at or above the freed start
        if (!rd_valid || rd_start >= astart_q[best_q]) begin
          pend_ok_d = rd_valid && rd_start ==
                      astart_q[best_q] + alen_q[best_q];
          if (fidx_q != '0) begin
            fidx_d  = fidx_q - 1'b1;
            state_d = SPrev;
          end else begin
            state_d = SDecide;
          end
        end else if (fidx_q == FLast) begin
          // every entry lies below, the last one is the lower neighbour
          pend_ok_d = 1'b0;
          state_d   = SPrev;
        end else begin
          fidx_d = fidx_q + 1'b1;
        end
      end
      SPrev: begin
        // tap sits on the entry below the insertion point; step back to it
        fidx_d  = fidx_q + 1'b1;
        state_d = SDecide;
      end
      SDecide: begin
        // fidx now names the insertion point
        if (rd_prev_ok_q && pend_ok_q) begin
          ctl.cmd = ffca_pkg::FcMerge;
          ctl.pos = 9'(fidx_q - 1'b1);
          ctl.len = 32'(alen_q[best_q]);
          state_d = SRelease;
        end else if (rd_prev_ok_q) begin
          ctl.cmd = ffca_pkg::FcGrowPrev;
          ctl.pos = 9'(fidx_q - 1'b1);
          ctl.len = 32'(alen_q[best_q]);
          state_d = SRelease;
        end else if (pend_ok_q) begin
          ctl.cmd   = ffca_pkg::FcGrowNext;
          ctl.pos   = 9'(fidx_q);
          ctl.start = 32'(astart_q[best_q]);
          ctl.len   = 32'(alen_q[best_q]);
          state_d   = SRelease;
        end else if (f_full) begin
          st_d    = ffca_pkg::StFull;
          state_d = SOut;
        end else begin
          ctl.cmd   = ffca_pkg::FcInsert;
          ctl.pos   = 9'(fidx_q);
          ctl.start = 32'(astart_q[best_q]);
          ctl.len   = 32'(alen_q[best_q]);
          state_d   = SRelease;
        end
      end
      SRelease: begin
        do_release = 1'b1;
        rs_d       = astart_q[best_q];
        rl_d       = alen_q[best_q];
        st_d       = ffca_pkg::StOk;
        state_d    = SOut;
      end
      SOut: begin
        if (!out_v_q || m_axis_tready) begin
          out_v_d = 1'b1;
          if (st_q == ffca_pkg::StOk) begin
            out_d = {5'b0, 16'(rl_q), 16'(rs_q), st_q};
          end else begin
            out_d = {37'b0, st_q};
          end
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // lower neighbour check, captured while the scan tap sits on it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_prev_ok_q <= 1'b0;
    end else if (state_q == SPrev) begin
      rd_prev_ok_q <= rd_valid && (rd_start + rd_len == astart_q[best_q]) &&
                      (rd_start < astart_q[best_q]);
    end else if (state_q == SPosScan) begin
      rd_prev_ok_q <= 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      out_v_q   <= 1'b0;
      slot_ok_q <= 1'b0;
      best_ok_q <= 1'b0;
      pend_ok_q <= 1'b0;
      fidx_q    <= '0;
      aidx_q    <= '0;
      st_q      <= ffca_pkg::StOk;
    end else begin
      state_q   <= state_d;
      out_v_q   <= out_v_d;
      slot_ok_q <= slot_ok_d;
      best_ok_q <= best_ok_d;
      pend_ok_q <= pend_ok_d;
      fidx_q    <= fidx_d;
      aidx_q    <= aidx_d;
      st_q      <= st_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    slot_q     <= slot_d;
    best_q     <= best_d;
    best_age_q <= best_age_d;
    rs_q       <= rs_d;
    rl_q       <= rl_d;
    out_q      <= out_d;
    if (s_axis_tvalid && s_axis_tready) begin
      mode_q <= s_axis_tuser;
      pid_q  <= s_axis_tdata[15:0];
      size_q <= s_axis_tdata[31:16];
    end
  end

  // allocation table valid bits and recency ranks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      av_q  <= '0;
      age_q <= '0;
    end else if (cfg_we_i) begin
      av_q  <= '0;
      age_q <= '0;
    end else if (do_alloc) begin
      for (int i = 0; i < ALLOC_ENTRIES; i++) begin
        if (av_q[i]) age_q[i] <= age_q[i] + 1'b1;
      end
      av_q[slot_q]  <= 1'b1;
      age_q[slot_q] <= '0;
    end else if (do_release) begin
      for (int i = 0; i < ALLOC_ENTRIES; i++) begin
        if (av_q[i] && age_q[i] > age_q[best_q]) age_q[i] <= age_q[i] - 1'b1;
      end
      av_q[best_q]  <= 1'b0;
      age_q[best_q] <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_alloc) begin
      owner_q[slot_q]  <= pid_q;
      astart_q[slot_q] <= rs_q;
      alen_q[slot_q]   <= rl_q;
    end
  end

  `include "first_fit_coalescing_allocator_core_macros.svh"

  `FFCA_ASSERT(a_ready_idle, s_axis_tready |-> state_q == SIdle, "ready outside idle")
  `FFCA_ASSERT(a_out_hold, out_v_q && !m_axis_tready |=> out_v_q && $stable(out_q), "response lost")
  `FFCA_NEVER(a_no_double, do_alloc && do_release, "alloc and release together")
  `FFCA_ASSERT(a_ok_size, out_v_q && out_q[2:0] == ffca_pkg::StOk |-> out_q[34:19] != '0, "ok with zero size")

endmodule

### sim/tb_first_fit_coalescing_allocator_core.sv
// testbench for the first-fit coalescing allocator: directed and random requests against a predictor
module tb_first_fit_coalescing_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NFree  = 16;
  localparam int NAlloc = 16;
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;
  localparam int CycleLimit = 1000000;

  typedef struct packed {
    logic        mode;
    logic [15:0] pid;
    logic [15:0] size;
  } alloc_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] rstart;
    logic [15:0] rsize;
  } alloc_rsp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  first_fit_coalescing_allocator_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // predictor state
  logic [15:0] mem_units;
  logic [15:0] fr_start [NFree];
  logic [15:0] fr_len   [NFree];
  int          fr_count;
  logic [15:0] al_owner [NAlloc];
  logic [15:0] al_start [NAlloc];
  logic [15:0] al_len   [NAlloc];
  logic        al_valid [NAlloc];
  int          al_age   [NAlloc];

  alloc_req_t  pending_reqs[$];
  alloc_rsp_t  expected_rsps[$];
  int          mismatches = 0;
  int          cycles = 0;
  int          src_idle_pct = 9;
  int          snk_idle_pct = 69;
  logic        hold_src = 1'b0;

  function automatic void clear_tables();
    for (int i = 0; i < NFree; i++) begin
      fr_start[i] = '0;
      fr_len[i] = '0;
    end
    for (int i = 0; i < NAlloc; i++) begin
      al_valid[i] = 1'b0;
      al_age[i] = 0;
    end
    fr_count = (mem_units != 0) ? 1 : 0;
    fr_len[0] = mem_units;
  endfunction

  function automatic void free_drop(int idx);
    for (int i = idx; i + 1 < fr_count; i++) begin
      fr_start[i] = fr_start[i+1];
      fr_len[i] = fr_len[i+1];
    end
    fr_count--;
  endfunction

  // return region to the sorted free table, merging with neighbours
  function automatic bit free_return(logic [15:0] st, logic [15:0] ln);
    int pos;
    bit jp, jn;
    logic [16:0] fin;
    pos = 0;
    fin = st + ln;
    while (pos < fr_count && fr_start[pos] < st) pos++;
    jp = pos > 0 && ({1'b0, fr_start[pos-1]} + fr_len[pos-1]) == {1'b0, st};
    jn = pos < fr_count && {1'b0, fr_start[pos]} == fin;
    if (jp && jn) begin
      fr_len[pos-1] = fr_len[pos-1] + ln + fr_len[pos];
      free_drop(pos);
    end else if (jp) begin
      fr_len[pos-1] = fr_len[pos-1] + ln;
    end else if (jn) begin
      fr_start[pos] = st;
      fr_len[pos] = fr_len[pos] + ln;
    end else begin
      if (fr_count >= NFree) return 1'b0;
      for (int i = fr_count; i > pos; i--) begin
        fr_start[i] = fr_start[i-1];
        fr_len[i] = fr_len[i-1];
      end
      fr_start[pos] = st;
      fr_len[pos] = ln;
      fr_count++;
    end
    return 1'b1;
  endfunction

  function automatic alloc_rsp_t predict_rsp(alloc_req_t rq);
    alloc_rsp_t r;
    int slot, i, best;
    r = '0;
    if (rq.mode == MODE_ALLOC) begin
      slot = -1;
      for (i = 0; i < NAlloc; i++) if (!al_valid[i] && slot < 0) slot = i;
      if (rq.size == 0) r.status = ffca_pkg::StZero;
      else if (slot < 0) r.status = ffca_pkg::StFull;
      else begin
        for (i = 0; i < fr_count; i++) if (fr_len[i] >= rq.size) break;
        if (i >= fr_count) r.status = ffca_pkg::StNoSpace;
        else begin
          r = '{ffca_pkg::StOk, fr_start[i], rq.size};
          if (fr_len[i] == rq.size) free_drop(i);
          else begin
            fr_start[i] = fr_start[i] + rq.size;
            fr_len[i] = fr_len[i] - rq.size;
          end
          for (int k = 0; k < NAlloc; k++) if (al_valid[k]) al_age[k]++;
          al_owner[slot] = rq.pid;
          al_start[slot] = r.rstart;
          al_len[slot] = rq.size;
          al_valid[slot] = 1'b1;
          al_age[slot] = 0;
        end
      end
    end else begin
      best = -1;
      for (i = 0; i < NAlloc; i++)
        if (al_valid[i] && al_owner[i] == rq.pid && (best < 0 || al_age[i] < al_age[best]))
          best = i;
      if (best < 0) r.status = ffca_pkg::StNotFound;
      else if (!free_return(al_start[best], al_len[best])) r.status = ffca_pkg::StFull;
      else begin
        r = '{ffca_pkg::StOk, al_start[best], al_len[best]};
        for (i = 0; i < NAlloc; i++)
          if (al_valid[i] && al_age[i] > al_age[best]) al_age[i]--;
        al_valid[best] = 1'b0;
        al_age[best] = 0;
      end
    end
    return r;
  endfunction

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) void'(pending_reqs.pop_front());
      if ((!s_axis_tvalid || s_axis_tready) && !hold_src) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {pending_reqs[0].size, pending_reqs[0].pid};
          s_axis_tuser <= pending_reqs[0].mode;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end else if (!s_axis_tvalid || s_axis_tready) begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // predict on each accepted request
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      expected_rsps.push_back(predict_rsp('{s_axis_tuser, s_axis_tdata[15:0],
                                            s_axis_tdata[31:16]}));
  end

  // response monitor
  always @(posedge clk_i) begin
    alloc_rsp_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[2:0], m_axis_tdata[18:3], m_axis_tdata[34:19]};
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response %h", got);
        end else begin
          want = expected_rsps.pop_front();
          if (got.status !== want.status || got.rstart !== want.rstart
              || got.rsize !== want.rsize) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp st=%0d start=%0d size=%0d, got st=%0d start=%0d size=%0d",
                       want.status, want.rstart, want.rsize,
                       got.status, got.rstart, got.rsize);
          end
        end
      end
      m_axis_tready <= $urandom_range(99) >= snk_idle_pct;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || s_axis_tvalid || expected_rsps.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_size(logic [15:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mem_units = v;
    clear_tables();
  endtask

  function automatic void push_req(logic m, logic [15:0] p, logic [15:0] s);
    pending_reqs.push_back('{m, p, s});
  endfunction

  // one random phase: mostly alloc/free of a small set of pids
  task automatic random_phase(int n, int max_sz);
    for (int i = 0; i < n; i++) begin
      int k;
      k = $urandom_range(99);
      if (k < 3) push_req(1'($urandom_range(1)), 16'($urandom), 16'($urandom));
      else if (k < 55)
        push_req(MODE_ALLOC, 16'($urandom_range(7)), 16'($urandom_range(max_sz)));
      else push_req(MODE_FREE, 16'($urandom_range(8)), 16'($urandom));
    end
  endtask

  initial begin
    mem_units = ffca_pkg::DefaultMemorySize;
    clear_tables();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero size, no space, several per pid, unknown pid, table full
    push_req(MODE_ALLOC, 16'd1, 16'd0);
    push_req(MODE_ALLOC, 16'hFFFF, 16'hFFFF);
    push_req(MODE_FREE, 16'd5, 16'd0);
    push_req(MODE_ALLOC, 16'd1, 16'd100);
    push_req(MODE_ALLOC, 16'd1, 16'd200);
    push_req(MODE_ALLOC, 16'd2, 16'd300);
    push_req(MODE_FREE, 16'd1, 16'hFFFF);
    push_req(MODE_FREE, 16'd1, 16'd0);
    push_req(MODE_ALLOC, 16'd3, 16'd50);
    push_req(MODE_ALLOC, 16'd4, 16'd3650);
    push_req(MODE_FREE, 16'd2, 16'd0);
    push_req(MODE_FREE, 16'd3, 16'd0);
    push_req(MODE_FREE, 16'd4, 16'd0);
    for (int i = 0; i < 17; i++) push_req(MODE_ALLOC, 16'hFFFF, 16'd1);
    wait_drained();

    // free every other block, then an exact fit and frees that join their free neighbours
    hold_src = 1'b1;
    wait_drained();
    hold_src = 1'b0;
    write_size(16'd40);
    for (int i = 0; i < 16; i++) push_req(MODE_ALLOC, 16'(100 + i), 16'd2);
    for (int i = 0; i < 16; i += 2) push_req(MODE_FREE, 16'(100 + i), 16'd0);
    push_req(MODE_ALLOC, 16'd9, 16'd8);
    push_req(MODE_FREE, 16'd115, 16'd0);
    push_req(MODE_FREE, 16'd113, 16'd0);
    wait_drained();

    write_size(16'd0);
    push_req(MODE_ALLOC, 16'd1, 16'd1);
    push_req(MODE_FREE, 16'd1, 16'd0);
    wait_drained();

    write_size(16'hFFFF);
    random_phase(260, 12000);
    wait_drained();

    src_idle_pct = 69;
    snk_idle_pct = 9;
    write_size(16'd1);
    push_req(MODE_ALLOC, 16'd0, 16'd1);
    push_req(MODE_FREE, 16'd0, 16'd0);
    wait_drained();
    write_size(16'd300);
    random_phase(260, 60);
    wait_drained();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_size(16'd4000);
    random_phase(260, 700);
    wait_drained();

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/ffca_pkg.sv
hw/rtl/ffca_free_cell.sv
hw/rtl/ffca_free_chain.sv
hw/rtl/first_fit_coalescing_allocator_core.sv
sim/tb_first_fit_coalescing_allocator_core.sv
